// ===== sv/owbm_pkg.sv =====
// Shared types and constants of the 1-Wire bus master.
// Used by owbm_regs, owbm_seq and one_wire_bus_master_core; depends on nothing.
`default_nettype none

package owbm_pkg;

    // Configuration register file
    localparam int NUM_REGS  = 8;
    localparam int REG_WIDTH = 10;

    typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] cfg_t;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_RST_LOW     = 3'd0;
    localparam reg_idx_t REG_PRES_SAMPLE = 3'd1;
    localparam reg_idx_t REG_RST_RECOVER = 3'd2;
    localparam reg_idx_t REG_SLOT_START  = 3'd3;
    localparam reg_idx_t REG_WRITE_SLOT  = 3'd4;
    localparam reg_idx_t REG_READ_SAMPLE = 3'd5;
    localparam reg_idx_t REG_READ_RECOV  = 3'd6;
    localparam reg_idx_t REG_WRITE_TAIL  = 3'd7;

    // Reset values, register 7 first
    localparam cfg_t CFG_RESET = {10'd100, 10'd120, 10'd14, 10'd100,
                                  10'd1, 10'd430, 10'd100, 10'd500};

    // Command codes
    typedef logic [2:0] op_t;

    localparam op_t OP_TICK  = 3'd0;
    localparam op_t OP_RESET = 3'd1;
    localparam op_t OP_WRITE = 3'd2;
    localparam op_t OP_READ  = 3'd3;
    localparam op_t OP_ROM   = 3'd4;

    localparam logic [7:0] READ_ROM_CMD = 8'h33;

    // Bus sequencer phases
    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_RST_WAIT = 10'b00_0000_0100,
        PH_RST_REC  = 10'b00_0000_1000,
        PH_W_START  = 10'b00_0001_0000,
        PH_W_REST   = 10'b00_0010_0000,
        PH_W_TAIL   = 10'b00_0100_0000,
        PH_R_START  = 10'b00_1000_0000,
        PH_R_WAIT   = 10'b01_0000_0000,
        PH_R_REC    = 10'b10_0000_0000
    } phase_t;

    // One input beat, split into its fields
    typedef struct packed {
        logic       line_in;
        logic [7:0] data_in;
        op_t        op;
    } item_t;

    // One result beat
    typedef struct packed {
        logic       rejected;
        logic       last_byte;
        logic [2:0] byte_index;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       device_present;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/owbm_regs.sv =====
// APB-style configuration register file of the 1-Wire bus master.
// Depends on owbm_pkg for the register layout and reset values.
`default_nettype none

module owbm_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output owbm_pkg::cfg_t           cfg
);

    owbm_pkg::cfg_t     cfg_reg;
    owbm_pkg::reg_idx_t addr_idx;
    logic               wr_en;

    assign addr_idx = paddr[4:2];
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= owbm_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            cfg_reg[addr_idx] <= pwdata[owbm_pkg::REG_WIDTH-1:0];
        end
    end

    // Read data is the addressed register, zero-extended
    assign prdata = {{(32 - owbm_pkg::REG_WIDTH){1'b0}}, cfg_reg[addr_idx]};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/owbm_seq.sv =====
// Bus sequencer of the 1-Wire master: phase state, tick timer, bit and byte
// counters, and the per-tick next-state and result logic. Depends on owbm_pkg.
`default_nettype none

module owbm_seq #(
    parameter int ROM_BYTES  = 8,
    parameter int TIMER_BITS = 10
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire owbm_pkg::item_t item,
    input  wire owbm_pkg::cfg_t  cfg,
    output owbm_pkg::result_t    result
);

    localparam int DW = (TIMER_BITS > owbm_pkg::REG_WIDTH) ? TIMER_BITS
                                                           : owbm_pkg::REG_WIDTH;
    localparam logic [DW-1:0] TMAX = DW'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [3:0]    ROM_LAST = 4'(ROM_BYTES);

    typedef logic [TIMER_BITS-1:0] tmr_t;

    // Phase length from a register: optional floor of one, saturate to timer
    function automatic tmr_t dur(input logic [owbm_pkg::REG_WIDTH-1:0] r,
                                 input logic min_one);
        logic [DW-1:0] d;
        begin
            d = DW'(r);
            if (min_one && (d == '0))
            begin
                d = DW'(1);
            end
            if (d > TMAX)
            begin
                d = TMAX;
            end
            dur = d[TIMER_BITS-1:0];
        end
    endfunction

    tmr_t d_rst_low, d_pres, d_rst_rec, d_slot, d_wslot, d_rsample, d_rrec, d_tail;

    assign d_rst_low = dur(cfg[owbm_pkg::REG_RST_LOW],     1'b1);
    assign d_pres    = dur(cfg[owbm_pkg::REG_PRES_SAMPLE], 1'b1);
    assign d_rst_rec = dur(cfg[owbm_pkg::REG_RST_RECOVER], 1'b0);
    assign d_slot    = dur(cfg[owbm_pkg::REG_SLOT_START],  1'b1);
    assign d_wslot   = dur(cfg[owbm_pkg::REG_WRITE_SLOT],  1'b1);
    assign d_rsample = dur(cfg[owbm_pkg::REG_READ_SAMPLE], 1'b1);
    assign d_rrec    = dur(cfg[owbm_pkg::REG_READ_RECOV],  1'b0);
    assign d_tail    = dur(cfg[owbm_pkg::REG_WRITE_TAIL],  1'b0);

    owbm_pkg::phase_t phase_reg, phase_next;
    owbm_pkg::op_t    cmd_reg, cmd_next;
    tmr_t             timer_reg, timer_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [7:0]       shift_reg, shift_next;
    logic [2:0]       rom_cnt_reg, rom_cnt_next;
    logic             presence_reg, presence_next;

    logic             rst_rec_fin, tail_fin, rrec_fin, rom_last;

    // Next state and result of one tick
    always_comb
    begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        timer_next    = timer_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        rom_cnt_next  = rom_cnt_reg;
        presence_next = presence_reg;
        rst_rec_fin   = 1'b0;
        tail_fin      = 1'b0;
        rrec_fin      = 1'b0;
        rom_last      = 1'b0;
        result        = '0;

        // Command start, or rejection while a command runs
        if ((item.op == owbm_pkg::OP_RESET) || (item.op == owbm_pkg::OP_WRITE) ||
            (item.op == owbm_pkg::OP_READ) || (item.op == owbm_pkg::OP_ROM))
        begin
            if (phase_reg != owbm_pkg::PH_IDLE)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                cmd_next     = item.op;
                bit_cnt_next = 3'd0;
                rom_cnt_next = 3'd0;
                case (item.op)
                    owbm_pkg::OP_WRITE:
                    begin
                        shift_next = item.data_in;
                        phase_next = owbm_pkg::PH_W_START;
                        timer_next = d_slot;
                    end
                    owbm_pkg::OP_READ:
                    begin
                        shift_next = 8'd0;
                        phase_next = owbm_pkg::PH_R_START;
                        timer_next = d_slot;
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_RST_LOW;
                        timer_next = d_rst_low;
                    end
                endcase
            end
        end

        // Line drive and timer count for the current phase
        if (phase_next != owbm_pkg::PH_IDLE)
        begin
            if ((phase_next == owbm_pkg::PH_RST_LOW) ||
                (phase_next == owbm_pkg::PH_W_START) ||
                (phase_next == owbm_pkg::PH_R_START))
            begin
                result.drive_low = 1'b1;
            end
            else if (phase_next == owbm_pkg::PH_W_REST)
            begin
                result.drive_low = ~shift_next[bit_cnt_next];
            end

            timer_next = timer_next - tmr_t'(1);

            // Phase end; phases of zero length finish on the same tick
            if (timer_next == '0)
            begin
                case (phase_next)
                    owbm_pkg::PH_RST_LOW:
                    begin
                        phase_next = owbm_pkg::PH_RST_WAIT;
                        timer_next = d_pres;
                    end
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        presence_next = ~item.line_in;
                        if (d_rst_rec == '0)
                        begin
                            rst_rec_fin = 1'b1;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_RST_REC;
                            timer_next = d_rst_rec;
                        end
                    end
                    owbm_pkg::PH_RST_REC:
                    begin
                        rst_rec_fin = 1'b1;
                    end
                    owbm_pkg::PH_W_START:
                    begin
                        phase_next = owbm_pkg::PH_W_REST;
                        timer_next = d_wslot;
                    end
                    owbm_pkg::PH_W_REST:
                    begin
                        if (bit_cnt_next == 3'd7)
                        begin
                            bit_cnt_next = 3'd0;
                            if (d_tail == '0)
                            begin
                                tail_fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = owbm_pkg::PH_W_TAIL;
                                timer_next = d_tail;
                            end
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_next + 3'd1;
                            phase_next   = owbm_pkg::PH_W_START;
                            timer_next   = d_slot;
                        end
                    end
                    owbm_pkg::PH_W_TAIL:
                    begin
                        tail_fin = 1'b1;
                    end
                    owbm_pkg::PH_R_START:
                    begin
                        phase_next = owbm_pkg::PH_R_WAIT;
                        timer_next = d_rsample;
                    end
                    owbm_pkg::PH_R_WAIT:
                    begin
                        shift_next = {item.line_in, shift_next[7:1]};
                        if (d_rrec == '0)
                        begin
                            rrec_fin = 1'b1;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_R_REC;
                            timer_next = d_rrec;
                        end
                    end
                    owbm_pkg::PH_R_REC:
                    begin
                        rrec_fin = 1'b1;
                    end
                    default:
                    begin
                        phase_next      = owbm_pkg::PH_IDLE;
                        timer_next      = '0;
                        result.done_res = 1'b1;
                    end
                endcase

                // End of reset recovery: read ROM goes on with the command byte
                if (rst_rec_fin)
                begin
                    if (cmd_next == owbm_pkg::OP_ROM)
                    begin
                        shift_next   = owbm_pkg::READ_ROM_CMD;
                        bit_cnt_next = 3'd0;
                        phase_next   = owbm_pkg::PH_W_START;
                        timer_next   = d_slot;
                    end
                    else
                    begin
                        phase_next      = owbm_pkg::PH_IDLE;
                        timer_next      = '0;
                        result.done_res = 1'b1;
                    end
                end

                // End of the write tail: read ROM goes on with the first byte
                if (tail_fin)
                begin
                    if (cmd_next == owbm_pkg::OP_ROM)
                    begin
                        bit_cnt_next = 3'd0;
                        shift_next   = 8'd0;
                        rom_cnt_next = 3'd0;
                        phase_next   = owbm_pkg::PH_R_START;
                        timer_next   = d_slot;
                    end
                    else
                    begin
                        phase_next      = owbm_pkg::PH_IDLE;
                        timer_next      = '0;
                        result.done_res = 1'b1;
                    end
                end

                // End of read recovery: next bit, next byte or done
                if (rrec_fin)
                begin
                    if (bit_cnt_next == 3'd7)
                    begin
                        rom_last = (({1'b0, rom_cnt_next} + 4'd1) >= ROM_LAST);
                        result.byte_valid = 1'b1;
                        result.byte_out   = shift_next;
                        if (cmd_next == owbm_pkg::OP_ROM)
                        begin
                            result.byte_index = rom_cnt_next;
                            result.last_byte  = rom_last;
                        end
                        else
                        begin
                            result.last_byte = 1'b1;
                        end
                        if ((cmd_next == owbm_pkg::OP_ROM) && !rom_last)
                        begin
                            rom_cnt_next = rom_cnt_next + 3'd1;
                            bit_cnt_next = 3'd0;
                            shift_next   = 8'd0;
                            phase_next   = owbm_pkg::PH_R_START;
                            timer_next   = d_slot;
                        end
                        else
                        begin
                            phase_next      = owbm_pkg::PH_IDLE;
                            timer_next      = '0;
                            result.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_next + 3'd1;
                        phase_next   = owbm_pkg::PH_R_START;
                        timer_next   = d_slot;
                    end
                end
            end
        end

        result.busy_res       = (phase_next != owbm_pkg::PH_IDLE);
        result.device_present = presence_next;
    end

    // State registers advance once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= owbm_pkg::PH_IDLE;
            cmd_reg      <= owbm_pkg::OP_TICK;
            timer_reg    <= '0;
            bit_cnt_reg  <= 3'd0;
            shift_reg    <= 8'd0;
            rom_cnt_reg  <= 3'd0;
            presence_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            timer_reg    <= timer_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            rom_cnt_reg  <= rom_cnt_next;
            presence_reg <= presence_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master_core.sv =====
// Top level of the single-pin 1-Wire bus master: input register, sequencer,
// result register and configuration port. Depends on owbm_pkg, owbm_regs, owbm_seq.
`default_nettype none

// Usage:
// Each beat on the s_ side is one microsecond tick. It carries the sampled bus
// level and optionally a command (reset, write byte, read byte, read ROM),
// which starts only while the master is idle; a command given while busy is
// dropped and flagged as rejected in that tick's result.
// Each accepted beat yields exactly one result beat on the m_ side with the
// line drive level, busy, done, presence and any completed read byte; tlast
// marks the final byte of a read ROM or of a single byte read.
// An accepted beat is held in the input register; the sequencer result for it
// is then captured in the result register. Throughput is one beat per cycle
// while m_tready stays high, set by the combinational sequencer step.
// When m_tready is low the result is held, one more beat is taken into the
// input register, and s_tready then drops until the result is taken.
// Reset empties both registers, puts the sequencer in idle with the bus
// released and loads the default timing registers. The user must write the APB
// registers only while no tick is in flight; the block does not enforce this.
module one_wire_bus_master_core #(
    parameter int ROM_BYTES  = 8,
    parameter int TIMER_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // op[2:0], data_in[10:3], line_in[11], zero[15:12]
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                        // device_present[3], byte_out[11:4],
                                        // byte_valid[12], byte_index[15:13],
                                        // rejected[16], zero[23:17]
    output logic             m_tlast,   // last_byte
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    owbm_pkg::cfg_t    cfg;
    owbm_pkg::item_t   in_data_reg;
    logic              in_valid_reg;
    owbm_pkg::result_t step_res;
    owbm_pkg::result_t out_data_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              step_en;
    logic              s_beat;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_beat   = s_tvalid && s_tready;

    owbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_beat)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_data_reg <= s_tdata[11:0];
        end
    end

    owbm_seq #(
        .ROM_BYTES  (ROM_BYTES),
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_data_reg <= step_res;
        end
    end

    // Result beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.last_byte;
    assign m_tdata  = {7'd0,
                       out_data_reg.rejected,
                       out_data_reg.byte_index,
                       out_data_reg.byte_valid,
                       out_data_reg.byte_out,
                       out_data_reg.device_present,
                       out_data_reg.done_res,
                       out_data_reg.busy_res,
                       out_data_reg.drive_low};

endmodule

`default_nettype wire

// ===== tb/sv/one_wire_bus_master_checker.sv =====
// Checker for the 1-Wire bus master core: follows the tick, result and APB channels,
// keeps its own copy of the timing registers and sequencer, and scores every result beat.
// Depends on owbm_pkg for the phase, command and beat types.
module one_wire_bus_master_checker #(
    parameter int ROM_BYTES  = 8,
    parameter int TIMER_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], data_in[10:3], line_in[11], zero[15:12]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // drive_low, busy, done, present, byte_out[11:4],
                                   // byte_valid, byte_index[15:13], rejected, zero
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        end_of_test,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    // Shadow of the timing registers and of the bus sequencer
    cfg_t        timing;
    phase_t      bus_phase;
    op_t         active_cmd;
    int unsigned phase_left;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_q;
    logic [2:0]  rom_pos;
    logic        presence_q;

    // Events raised during the tick being predicted
    logic        done_ev;
    logic        byte_ev;
    logic [7:0]  byte_val;
    logic [2:0]  byte_pos;
    logic        last_ev;

    // Results still owed by the block, oldest first
    result_t     tick_results[$];
    logic        end_done;

    task automatic report_mismatch(string what, longint unsigned got_v,
                                   longint unsigned want_v);
        fail_count++;
        if (fail_count <= 100)
        begin
            $display("MISMATCH %s: got %0h, expected %0h (at %0t)", what, got_v, want_v, $time);
        end
    endtask

    task automatic check_field(string what, longint unsigned got_v, longint unsigned want_v);
        if (got_v != want_v)
        begin
            report_mismatch(what, got_v, want_v);
        end
    endtask

    // Length of a phase in ticks. Registers that may be zero skip their phase,
    // the others treat zero as one tick.
    function automatic int unsigned phase_ticks(phase_t p);
        reg_idx_t    idx;
        int unsigned d;
        bit          may_skip;
        case (p)
            PH_RST_LOW:             idx = REG_RST_LOW;
            PH_RST_WAIT:            idx = REG_PRES_SAMPLE;
            PH_RST_REC:             idx = REG_RST_RECOVER;
            PH_W_START, PH_R_START: idx = REG_SLOT_START;
            PH_W_REST:              idx = REG_WRITE_SLOT;
            PH_W_TAIL:              idx = REG_WRITE_TAIL;
            PH_R_WAIT:              idx = REG_READ_SAMPLE;
            default:                idx = REG_READ_RECOV;
        endcase
        d = timing[idx];
        may_skip = (idx == REG_RST_RECOVER) || (idx == REG_READ_RECOV) ||
                   (idx == REG_WRITE_TAIL);
        if (d == 0 && !may_skip)
        begin
            d = 1;
        end
        if (d > (1 << TIMER_BITS) - 1)
        begin
            d = (1 << TIMER_BITS) - 1;
        end
        return d;
    endfunction

    // Enter a phase; returns 1 when it lasts no tick and must close at once.
    function automatic bit enter_phase(phase_t p);
        bus_phase  = p;
        phase_left = phase_ticks(p);
        return phase_left == 0;
    endfunction

    function automatic void end_command();
        bus_phase  = PH_IDLE;
        phase_left = 0;
        done_ev    = 1'b1;
    endfunction

    function automatic logic line_level(phase_t p);
        if (p == PH_RST_LOW || p == PH_W_START || p == PH_R_START)
        begin
            return 1'b1;
        end
        if (p == PH_W_REST)
        begin
            return ~shift_q[bit_pos];
        end
        return 1'b0;
    endfunction

    // Close the current phase and step through any phases of zero length.
    function automatic void close_phase(logic line);
        bit more;
        bit is_rom;
        bit is_last;
        more = 1'b1;
        while (more)
        begin
            more = 1'b0;
            case (bus_phase)
                PH_RST_LOW: more = enter_phase(PH_RST_WAIT);
                PH_RST_WAIT:
                begin
                    presence_q = ~line;
                    more = enter_phase(PH_RST_REC);
                end
                PH_RST_REC:
                begin
                    if (active_cmd == OP_ROM)
                    begin
                        shift_q = READ_ROM_CMD;
                        bit_pos = '0;
                        more = enter_phase(PH_W_START);
                    end
                    else
                    begin
                        end_command();
                    end
                end
                PH_W_START: more = enter_phase(PH_W_REST);
                PH_W_REST:
                begin
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        more = enter_phase(PH_W_TAIL);
                    end
                    else
                    begin
                        bit_pos++;
                        more = enter_phase(PH_W_START);
                    end
                end
                PH_W_TAIL:
                begin
                    if (active_cmd == OP_ROM)
                    begin
                        bit_pos = '0;
                        shift_q = '0;
                        rom_pos = '0;
                        more = enter_phase(PH_R_START);
                    end
                    else
                    begin
                        end_command();
                    end
                end
                PH_R_START: more = enter_phase(PH_R_WAIT);
                PH_R_WAIT:
                begin
                    shift_q = {line, shift_q[7:1]};
                    more = enter_phase(PH_R_REC);
                end
                PH_R_REC:
                begin
                    if (bit_pos == 3'd7)
                    begin
                        is_rom   = (active_cmd == OP_ROM);
                        is_last  = !is_rom || (int'(rom_pos) + 1 >= ROM_BYTES);
                        byte_ev  = 1'b1;
                        byte_val = shift_q;
                        byte_pos = is_rom ? rom_pos : 3'd0;
                        last_ev  = is_last;
                        if (!is_last)
                        begin
                            rom_pos++;
                            bit_pos = '0;
                            shift_q = '0;
                            more = enter_phase(PH_R_START);
                        end
                        else
                        begin
                            end_command();
                        end
                    end
                    else
                    begin
                        bit_pos++;
                        more = enter_phase(PH_R_START);
                    end
                end
                default: end_command();
            endcase
        end
    endfunction

    // Advance the shadow sequencer by one tick and build the result it owes.
    function automatic result_t predict_tick(op_t op, logic [7:0] din, logic line);
        result_t r;
        r        = '0;
        done_ev  = 1'b0;
        byte_ev  = 1'b0;
        byte_val = '0;
        byte_pos = '0;
        last_ev  = 1'b0;

        if (op >= OP_RESET && op <= OP_ROM)
        begin
            if (bus_phase != PH_IDLE)
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                active_cmd = op;
                bit_pos    = '0;
                rom_pos    = '0;
                case (op)
                    OP_WRITE:
                    begin
                        shift_q = din;
                        void'(enter_phase(PH_W_START));
                    end
                    OP_READ:
                    begin
                        shift_q = '0;
                        void'(enter_phase(PH_R_START));
                    end
                    default: void'(enter_phase(PH_RST_LOW));
                endcase
            end
        end

        if (bus_phase != PH_IDLE)
        begin
            r.drive_low = line_level(bus_phase);
            if (phase_left > 0)
            begin
                phase_left--;
            end
            if (phase_left == 0)
            begin
                close_phase(line);
            end
        end

        r.busy_res       = (bus_phase != PH_IDLE);
        r.done_res       = done_ev;
        r.device_present = presence_q;
        r.byte_valid     = byte_ev;
        r.byte_out       = byte_val;
        r.byte_index     = byte_pos;
        r.last_byte      = last_ev;
        return r;
    endfunction

    // Score result beats, track register writes and predict every tick beat.
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        result_t want;
        if (!rst_n)
        begin
            timing     = CFG_RESET;
            bus_phase  = PH_IDLE;
            active_cmd = OP_TICK;
            phase_left = 0;
            bit_pos    = '0;
            shift_q    = '0;
            rom_pos    = '0;
            presence_q = 1'b0;
            tick_results.delete();
            fail_count = 0;
            end_done   = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (tick_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", m_tdata, 0);
                end
                else
                begin
                    want = tick_results.pop_front();
                    check_field("drive_low", m_tdata[0], want.drive_low);
                    check_field("busy_res", m_tdata[1], want.busy_res);
                    check_field("done_res", m_tdata[2], want.done_res);
                    check_field("device_present", m_tdata[3], want.device_present);
                    check_field("byte_out", m_tdata[11:4], want.byte_out);
                    check_field("byte_valid", m_tdata[12], want.byte_valid);
                    check_field("byte_index", m_tdata[15:13], want.byte_index);
                    check_field("rejected", m_tdata[16], want.rejected);
                    check_field("tdata padding", m_tdata[23:17], 0);
                    check_field("last_byte", m_tlast, want.last_byte);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                timing[paddr[4:2]] = pwdata[REG_WIDTH-1:0];
            end

            if (s_tvalid && s_tready)
            begin
                tick_results.push_back(predict_tick(op_t'(s_tdata[2:0]), s_tdata[10:3],
                                                    s_tdata[11]));
            end

            if (end_of_test && !end_done)
            begin
                end_done = 1'b1;
                if (tick_results.size() != 0)
                begin
                    report_mismatch("results never delivered", 0, tick_results.size());
                end
            end
        end
    end

endmodule

// ===== tb/sv/one_wire_bus_master_core_tb.sv =====
// Top of the 1-Wire bus master regression: clock, reset, tick stimulus, APB
// timing writes and the verdict. Depends on owbm_pkg, one_wire_bus_master_core
// and one_wire_bus_master_checker.
module one_wire_bus_master_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam int ROM_BYTES    = 8;
    localparam int TIMER_BITS   = 10;
    localparam int OP_CODES     = 8;
    localparam int LINE_LOW     = 0;
    localparam int LINE_HIGH    = 1;
    localparam int LINE_RAND    = 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_TICKS = 100;

    typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    flow_t       flow = FLOW_FREE;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_asks = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    logic        last_busy = 1'b0;
    logic        end_of_test = 1'b0;
    int          fail_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    one_wire_bus_master_core #(
        .ROM_BYTES (ROM_BYTES),
        .TIMER_BITS(TIMER_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    one_wire_bus_master_checker #(
        .ROM_BYTES (ROM_BYTES),
        .TIMER_BITS(TIMER_BITS)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .end_of_test(end_of_test),
        .fail_count (fail_count)
    );

    // Beats moved on each side, and the busy flag of the latest result.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            n_sent <= n_sent + 1;
        end
        if (m_tvalid && m_tready)
        begin
            n_recv    <= n_recv + 1;
            last_busy <= m_tdata[1];
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic set_flow(flow_t f);
        flow      = f;
        gap_pct   = (f == FLOW_SRC_GAPS) ? 75 : (f == FLOW_BOTH) ? 27 : 0;
        stall_pct = (f == FLOW_SINK_STALLS) ? 75 : (f == FLOW_BOTH) ? 27 : 0;
    endtask

    function automatic logic line_bit(int sel);
        if (sel == LINE_RAND)
        begin
            return 1'($urandom);
        end
        return sel[0];
    endfunction

    // Offer one tick beat after a random gap and wait until it is taken.
    task automatic send_beat(op_t op, logic [7:0] din, logic line);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < gap_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {4'b0000, line, din, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    // Stop offering ticks until every result owed has come back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (n_recv != n_sent);
    endtask

    // Plain ticks in batches until the master reports it is no longer busy.
    task automatic run_until_idle(int line_sel);
        do
        begin
            repeat (16) send_beat(OP_TICK, 8'($urandom), line_bit(line_sel));
            wait_results();
        end
        while (last_busy);
    endtask

    // Setup cycle then access cycle; the bus is left selected for the next write.
    task automatic apb_write(reg_idx_t idx, logic [REG_WIDTH-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(32 - REG_WIDTH){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_timings(cfg_t t);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_write(reg_idx_t'(i), t[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly very short timings so that whole commands fit in a phase.
    function automatic cfg_t random_timings();
        cfg_t t;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            t[i] = ($urandom_range(7) == 0) ? REG_WIDTH'($urandom_range(6))
                                            : REG_WIDTH'($urandom_range(1));
        end
        return t;
    endfunction

    // Random ticks with commands sprinkled in; many land while busy and are rejected.
    task automatic run_random(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3 && flow == FLOW_FREE)
            begin
                hold_asks++;
            end
            if (i == 2 * n / 3)
            begin
                wait_results();
            end
            pick = $urandom_range(99);
            if (pick < 88)
            begin
                send_beat(OP_TICK, 8'($urandom), 1'($urandom));
            end
            else if (pick < 97)
            begin
                send_beat(op_t'($urandom_range(OP_ROM, OP_RESET)), 8'($urandom), 1'($urandom));
            end
            else
            begin
                send_beat(op_t'($urandom_range(OP_CODES - 1, OP_ROM + 1)), 8'($urandom),
                          1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write byte on the timings left by reset; short timings take over mid-byte.
        set_flow(FLOW_SINK_STALLS);
        send_beat(OP_WRITE, 8'h5A, 1'b1);
        repeat (4)
        begin
            repeat (16) send_beat(OP_TICK, 8'($urandom), 1'b1);
            wait_results();
        end

        // Directed commands with all timings zero: shortest slots, skipped recoveries.
        load_timings('0);
        set_flow(FLOW_BOTH);
        run_until_idle(LINE_HIGH);
        send_beat(OP_RESET, 8'($urandom), 1'b0);
        run_until_idle(LINE_LOW);
        send_beat(OP_RESET, 8'($urandom), 1'b1);
        run_until_idle(LINE_HIGH);
        send_beat(OP_WRITE, 8'h00, line_bit(LINE_RAND));
        run_until_idle(LINE_RAND);
        send_beat(OP_WRITE, 8'hFF, line_bit(LINE_RAND));
        run_until_idle(LINE_RAND);
        send_beat(OP_READ, 8'($urandom), 1'b0);
        run_until_idle(LINE_LOW);
        send_beat(OP_READ, 8'($urandom), 1'b1);
        run_until_idle(LINE_HIGH);

        // Read ROM with no device answering still reads all bytes.
        send_beat(OP_ROM, 8'($urandom), 1'b1);
        run_until_idle(LINE_HIGH);

        // Every command while busy is rejected; unknown codes are ignored.
        send_beat(OP_WRITE, 8'h3C, line_bit(LINE_RAND));
        send_beat(OP_RESET, 8'($urandom), line_bit(LINE_RAND));
        send_beat(OP_WRITE, 8'hFF, line_bit(LINE_RAND));
        send_beat(OP_READ, 8'($urandom), line_bit(LINE_RAND));
        send_beat(OP_ROM, 8'($urandom), line_bit(LINE_RAND));
        for (int c = OP_ROM + 1; c < OP_CODES; c++)
        begin
            send_beat(op_t'(c), 8'($urandom), line_bit(LINE_RAND));
        end
        run_until_idle(LINE_RAND);
        for (int c = OP_ROM + 1; c < OP_CODES; c++)
        begin
            send_beat(op_t'(c), 8'($urandom), line_bit(LINE_RAND));
        end
        run_until_idle(LINE_RAND);

        // Random phases, one per flow-control pattern, each with fresh timings.
        for (int f = FLOW_FREE; f <= FLOW_BOTH; f++)
        begin
            load_timings(random_timings());
            set_flow(flow_t'(f));
            run_random(RANDOM_TICKS);
            run_until_idle(LINE_RAND);
        end

        // Let the pipeline settle, then ask the checker for leftovers.
        wait_results();
        repeat (8) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== one_wire_bus_master_core.f =====
sv/owbm_pkg.sv
sv/owbm_regs.sv
sv/owbm_seq.sv
sv/one_wire_bus_master_core.sv
tb/sv/one_wire_bus_master_checker.sv
tb/sv/one_wire_bus_master_core_tb.sv
